// ===== src/msc_pkg.sv =====
// Shared widths, constants and control/status types for the min-squares block.
`timescale 1ns / 1ps
package msc_pkg;

  // Largest target the count table can hold.
  localparam int unsigned MaxN       = 1023;
  localparam int unsigned TableDepth = MaxN + 1;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CountW     = 3;
  localparam int unsigned RootW      = 6;
  localparam int unsigned SquareW    = 11;

  // Running minimum start value: no candidate seen yet.
  localparam logic [CountW-1:0] MinNone = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture target, start row 2
    logic init_zero;  // write table entry 0
    logic init_one;   // write table entry 1
    logic step;       // one inner step: fold previous read, issue next read
    logic row_write;  // write entry i, advance to next row
    logic small_res;  // result for targets 0 and 1
    logic publish;    // move result into the output register
  } msc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic small_n;    // target is 0 or 1
    logic sq_le_i;    // current square still fits under i
    logic pend;       // a table read is in flight
    logic last_row;   // i equals the target
    logic out_free;   // output register can take a result
  } msc_sts_t;

endpackage

// ===== src/min_squares_count.sv =====
// Top level: fewest perfect squares summing to a target, table filled per query.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid_i, in_ready_o, target_value_i | into block
//  out     | out_valid_o, out_ready_i, min_count_o  | out of block
//
// One query at a time. A target n >= 2 fills table rows 2..n; targets 0 and 1 skip
// the fill. Each row issues one table read per inner step while the square fits,
// drains the last read, then writes entry i. Reset clears the controller, counters
// and flags only; a query with n >= 2 rewrites table entries 0..n.
// A result waiting on out_ready_i does not block the next transfer on the input;
// a finished query holds until the output register is free.
`timescale 1ns / 1ps
module min_squares_count import msc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [AddrW-1:0]  target_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CountW-1:0] min_count_o
);

  msc_cmd_t cmd;
  msc_sts_t sts;

  msc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  msc_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .target_value_i (target_value_i),
    .min_count_o    (min_count_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i)
  );

`ifndef SYNTHESIS
  // A presented result never exceeds four squares.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (min_count_o <= CountW'(4)))
    else $error("min_count above 4");

  // After an input transfer the block is busy.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while busy");

  // A new result appears only from a publish command.
  a_publish_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.publish))
    else $error("output valid without publish");
`endif

endmodule

// ===== src/msc_ctrl.sv =====
// Controller state machine that sequences the table fill for one query.
`timescale 1ns / 1ps
module msc_ctrl import msc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  msc_sts_t sts_i,
  output msc_cmd_t cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StInit0  = 3'd1;
  localparam logic [2:0] StInit1  = 3'd2;
  localparam logic [2:0] StInner  = 3'd3;
  localparam logic [2:0] StWrRow  = 3'd4;
  localparam logic [2:0] StFinish = 3'd5;

  logic [2:0] state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StInit0;
        end
      end
      StInit0: begin
        if (sts_i.small_n) begin
          cmd_o.small_res = 1'b1;
          state_d         = StFinish;
        end else begin
          cmd_o.init_zero = 1'b1;
          state_d         = StInit1;
        end
      end
      StInit1: begin
        cmd_o.init_one = 1'b1;
        state_d        = StInner;
      end
      StInner: begin
        cmd_o.step = 1'b1;
        if (!sts_i.sq_le_i && !sts_i.pend) begin
          state_d = StWrRow;
        end
      end
      StWrRow: begin
        cmd_o.row_write = 1'b1;
        state_d         = sts_i.last_row ? StFinish : StInner;
      end
      StFinish: begin
        if (sts_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/msc_dpath.sv =====
// Datapath: count table memory, loop counters, running minimum, output register.
`timescale 1ns / 1ps
module msc_dpath import msc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  msc_cmd_t          cmd_i,
  output msc_sts_t          sts_o,
  input  logic [AddrW-1:0]  target_value_i,
  output logic [CountW-1:0] min_count_o,
  output logic              out_valid_o,
  input  logic              out_ready_i
);

  logic [CountW-1:0]  mem [TableDepth];
  logic [CountW-1:0]  rdata_q;

  logic [AddrW-1:0]   n_q, n_d;
  logic [AddrW-1:0]   i_q, i_d;
  logic [RootW-1:0]   j_q, j_d;
  logic [SquareW-1:0] sq_q, sq_d;
  logic [CountW-1:0]  min_q, min_d;
  logic               pend_q, pend_d;
  logic [CountW-1:0]  res_q, res_d;
  logic               out_valid_q, out_valid_d;
  logic [CountW-1:0]  out_q, out_d;

  logic               sq_le_i;
  logic               rd_en;
  logic [AddrW-1:0]   rd_addr;
  logic               wr_en;
  logic [AddrW-1:0]   wr_addr;
  logic [CountW-1:0]  wr_data;
  logic [CountW-1:0]  min_fold;
  logic [CountW-1:0]  min_plus;

  assign sq_le_i  = sq_q <= {1'b0, i_q};
  assign min_fold = (pend_q && (rdata_q < min_q)) ? rdata_q : min_q;
  assign min_plus = min_q + CountW'(1);

  // Table port selection
  assign rd_en   = cmd_i.step && sq_le_i;
  assign rd_addr = i_q - sq_q[AddrW-1:0];
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = i_q;
    wr_data = min_plus;
    if (cmd_i.init_zero) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = '0;
    end else if (cmd_i.init_one) begin
      wr_en   = 1'b1;
      wr_addr = AddrW'(1);
      wr_data = CountW'(1);
    end else if (cmd_i.row_write) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Counter, minimum and result updates
  always_comb begin
    n_d         = n_q;
    i_d         = i_q;
    j_d         = j_q;
    sq_d        = sq_q;
    min_d       = min_q;
    pend_d      = pend_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load) begin
      n_d    = target_value_i;
      i_d    = AddrW'(2);
      j_d    = RootW'(1);
      sq_d   = SquareW'(1);
      min_d  = MinNone;
      pend_d = 1'b0;
    end
    if (cmd_i.step) begin
      min_d  = min_fold;
      pend_d = sq_le_i;
      if (sq_le_i) begin
        // (j+1)^2 = j^2 + 2j + 1
        j_d  = j_q + RootW'(1);
        sq_d = sq_q + {{(SquareW-RootW-1){1'b0}}, j_q, 1'b1};
      end
    end
    if (cmd_i.row_write) begin
      res_d = min_plus;
      i_d   = i_q + AddrW'(1);
      j_d   = RootW'(1);
      sq_d  = SquareW'(1);
      min_d = MinNone;
    end
    if (cmd_i.small_res) begin
      res_d = {{(CountW-1){1'b0}}, n_q[0]};
    end
    if (cmd_i.publish) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      j_q         <= '0;
      sq_q        <= '0;
      min_q       <= MinNone;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      i_q         <= i_d;
      j_q         <= j_d;
      sq_q        <= sq_d;
      min_q       <= min_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  // Status back to the controller
  assign sts_o.small_n  = n_q <= AddrW'(1);
  assign sts_o.sq_le_i  = sq_le_i;
  assign sts_o.pend     = pend_q;
  assign sts_o.last_row = i_q == n_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign min_count_o = out_q;
  assign out_valid_o = out_valid_q;

endmodule

// ===== tb/tb_top.sv =====
// Testbench for min_squares_count: directed and random targets against a table-fill predictor.
`timescale 1ns / 1ps
module tb_top;
  import msc_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [AddrW-1:0]  target_value_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CountW-1:0] min_count_o;

  // Predictor state: its own count table, refilled for every target
  logic [CountW-1:0] square_counts [TableDepth];
  logic [CountW-1:0] expected_counts [$];

  int unsigned error_count    = 0;
  int unsigned targets_sent   = 0;
  int unsigned counts_checked = 0;
  int unsigned largest_target = 0;
  bit          idling_on      = 1'b1;

  min_squares_count dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .target_value_i(target_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .min_count_o   (min_count_o)
  );

  // 100 MHz clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Bottom-up fill: entry i is one more than the smallest entry i - j*j
  function automatic logic [CountW-1:0] fewest_squares(input logic [AddrW-1:0] n);
    logic [CountW-1:0] best;
    int                j;
    square_counts[0] = '0;
    if (n >= 1) square_counts[1] = CountW'(1);
    for (int i = 2; i <= int'(n); i++) begin
      best = MinNone;
      j = 1;
      while (j * j <= i) begin
        if (square_counts[i - j * j] < best) best = square_counts[i - j * j];
        j++;
      end
      square_counts[i] = best + CountW'(1);
    end
    return square_counts[n];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Input transfers queue a prediction; output transfers are checked in order
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_counts.push_back(fewest_squares(target_value_i));
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_counts.size() == 0) begin
        report_mismatch($sformatf("count %0d with no target pending", min_count_o));
      end else if (min_count_o !== expected_counts[0]) begin
        report_mismatch($sformatf("min_count %0d, expected %0d",
                                  min_count_o, expected_counts[0]));
        void'(expected_counts.pop_front());
      end else begin
        void'(expected_counts.pop_front());
      end
      counts_checked++;
    end
  end

  // Result side: ready drops in random bursts while idling is on
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idling_on && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Called at a falling edge; leaves valid high so back-to-back sends need no toggle
  task automatic send_target(input logic [AddrW-1:0] n);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    target_value_i <= n;
    do @(posedge clk_i); while (!in_ready_o);
    targets_sent++;
    if (32'(n) > largest_target) largest_target = 32'(n);
    @(negedge clk_i);
  endtask

  // Targets zero and one, then two through five
  task automatic test_small_targets();
    send_target(10'd0);
    send_target(10'd1);
    send_target(10'd2);
    send_target(10'd3);
    send_target(10'd4);
    send_target(10'd5);
  endtask

  // Perfect squares, two-square sums and numbers that need all four
  task automatic test_known_counts();
    send_target(10'd7);
    send_target(10'd12);
    send_target(10'd13);
    send_target(10'd15);
    send_target(10'd25);
    send_target(10'd28);
    send_target(10'd961);
    send_target(10'd1008);
  endtask

  // Field extremes and alternating bit patterns
  task automatic test_field_extremes();
    send_target(10'h3FF);
    send_target(10'h200);
    send_target(10'h1FF);
    send_target(10'h2AA);
    send_target(10'h155);
    send_target(10'd0);
  endtask

  // Mostly small targets to keep the run short, a few up to the top of the range
  function automatic logic [AddrW-1:0] pick_target();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return AddrW'($urandom_range(0, MaxN));
    if (pick <= 3) return AddrW'($urandom_range(64, 255));
    return AddrW'($urandom_range(0, 63));
  endfunction

  task automatic test_random_targets(input int unsigned count);
    repeat (count) send_target(pick_target());
  endtask

  // Closing stretch with both sides always ready
  task automatic test_back_to_back(input int unsigned count);
    idling_on = 1'b0;
    repeat (count) send_target(AddrW'($urandom_range(0, 63)));
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_small_targets();
    test_known_counts();
    test_field_extremes();
    test_random_targets(65);
    test_back_to_back(15);
    in_valid_i <= 1'b0;

    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Sent %0d targets (largest %0d), checked %0d counts", targets_sent,
             largest_target, counts_checked);
    $display("Random stalls on both channels, closing stretch at full rate");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: well above the slowest legal run with every target at 1023
  initial begin
    #200_000_000;
    $display("Timeout waiting on the block");
    $display("Some tests failed");
    $finish;
  end

endmodule
